@@ sv/kmc_pkg.sv @@
// Shared constants for the k-means clustering block: field widths, command
// codes, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kmc_pkg;

    localparam int DEF_MAX_POINTS   = 1024;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_MAX_DIM      = 8;

    localparam int DATA_W    = 16;
    localparam int CMD_W     = 2;
    localparam int IDX_OUT_W = 3;
    localparam int ITER_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD_POINT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_CENTROID = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN           = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_SQUARED  = 3'd4;

    localparam logic [3:0]  RST_NUM_CLUSTERS = 4'd2;
    localparam logic [3:0]  RST_DIMENSION    = 4'd2;
    localparam logic [10:0] RST_NUM_POINTS   = 11'd1;
    localparam logic [8:0]  RST_MAX_ITER     = 9'd300;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } kmc_div_ctrl_t;

endpackage
`default_nettype wire

@@ sv/kmc_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; a zero divisor gives a zero quotient.
`timescale 1ns / 1ps
`default_nettype none
module kmc_divider #(
    parameter int N = 27,
    parameter int D = 11
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic signed [N-1:0] dividend,
    input  wire logic [D-1:0]        divisor,
    output logic                     busy,
    output logic                     done,
    output logic signed [N-1:0]      quotient
);
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  mag_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic          zero_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [D:0]    rem_sh;
    logic [D:0]    rem_sub;
    logic          q_bit;

    always_comb begin
        rem_sh  = {rem_reg, mag_reg[N-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
                mag_reg  <= dividend[N-1] ? N'(-dividend) : dividend;
                neg_reg  <= dividend[N-1];
                zero_reg <= (divisor == '0);
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                mag_reg <= {mag_reg[N-2:0], q_bit};
                rem_reg <= q_bit ? rem_sub[D-1:0] : rem_sh[D-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? N'(-mag_reg) : mag_reg);

endmodule
`default_nettype wire

@@ sv/kmeans_clustering.sv @@
// Lloyd k-means: load items are accepted only while idle; a run item, per round,
// clears the k*d sums, assigns each point to its nearest centroid and adds it to
// that centroid's sums, divides each sum by its count in the serial divider and
// ends the round; it then emits each centroid coordinate. Reset is synchronous,
// active low; it clears control state, counts and configuration registers;
// memories stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_clustering #(
    parameter int MAX_POINTS   = kmc_pkg::DEF_MAX_POINTS,
    parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIM      = kmc_pkg::DEF_MAX_DIM
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [kmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [kmc_pkg::CMD_W-1:0]           s_command,
    input  wire logic signed [kmc_pkg::DATA_W-1:0]   s_coord_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [kmc_pkg::IDX_OUT_W-1:0]            m_cluster_index,
    output logic [kmc_pkg::IDX_OUT_W-1:0]            m_coord_index,
    output logic signed [kmc_pkg::DATA_W-1:0]        m_centroid_value,
    output logic [kmc_pkg::ITER_W-1:0]               m_iterations_used,
    output logic                                     m_last
);
    import kmc_pkg::*;

    // Derived sizes. Index widths never drop below one bit.
    localparam int PM_DEPTH = MAX_POINTS * MAX_DIM;
    localparam int CB       = MAX_CLUSTERS * MAX_DIM;
    localparam int PA_W  = (PM_DEPTH > 1) ? $clog2(PM_DEPTH) : 1;
    localparam int PB_W  = $clog2(PM_DEPTH + 1);
    localparam int CA_W  = (CB > 1) ? $clog2(CB) : 1;
    localparam int CB_W  = $clog2(CB + 1);
    localparam int CM_AW = $clog2(2 * CB);
    localparam int KC_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int KI_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DC_W  = $clog2(MAX_DIM + 1);
    localparam int NP_W  = $clog2(MAX_POINTS + 1);
    localparam int CNT_W = NP_W;
    localparam int SUM_W = DATA_W + NP_W;
    localparam int SQ_W  = 2 * DATA_W + 1;
    localparam int DIST_W = SQ_W + DC_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_DRD   = 4'd2;
    localparam logic [3:0] ST_DMUL  = 4'd3;
    localparam logic [3:0] ST_DADD  = 4'd4;
    localparam logic [3:0] ST_ARD   = 4'd5;
    localparam logic [3:0] ST_AWR   = 4'd6;
    localparam logic [3:0] ST_URD   = 4'd7;
    localparam logic [3:0] ST_UDIV  = 4'd8;
    localparam logic [3:0] ST_UWAIT = 4'd9;
    localparam logic [3:0] ST_UMUL  = 4'd10;
    localparam logic [3:0] ST_UADD  = 4'd11;
    localparam logic [3:0] ST_REND  = 4'd12;
    localparam logic [3:0] ST_ORD   = 4'd13;
    localparam logic [3:0] ST_OLD   = 4'd14;

    // Configuration registers.
    logic [3:0]  ncl_reg;
    logic [3:0]  dim_reg;
    logic [10:0] npt_reg;
    logic [8:0]  mit_reg;
    logic [31:0] eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncl_reg <= RST_NUM_CLUSTERS;
            dim_reg <= RST_DIMENSION;
            npt_reg <= RST_NUM_POINTS;
            mit_reg <= RST_MAX_ITER;
            eps_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_CLUSTERS: ncl_reg <= cfg_data[3:0];
                CFG_DIMENSION:    dim_reg <= cfg_data[3:0];
                CFG_NUM_POINTS:   npt_reg <= cfg_data[10:0];
                CFG_MAX_ITER:     mit_reg <= cfg_data[8:0];
                CFG_EPS_SQUARED:  eps_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Register values clamped to the sizes the memories were built for.
    logic [KC_W-1:0]   k_c;
    logic [DC_W-1:0]   dim_c;
    logic [NP_W-1:0]   np_c;
    logic [ITER_W-1:0] limit_c;
    logic [CB_W-1:0]   kd_c;
    logic [PB_W-1:0]   npd_c;

    always_comb begin
        if (ncl_reg == '0) k_c = KC_W'(1);
        else if (32'(ncl_reg) > MAX_CLUSTERS) k_c = KC_W'(MAX_CLUSTERS);
        else k_c = KC_W'(ncl_reg);
        if (dim_reg == '0) dim_c = DC_W'(1);
        else if (32'(dim_reg) > MAX_DIM) dim_c = DC_W'(MAX_DIM);
        else dim_c = DC_W'(dim_reg);
        if (npt_reg == '0) np_c = NP_W'(1);
        else if (32'(npt_reg) > MAX_POINTS) np_c = NP_W'(MAX_POINTS);
        else np_c = NP_W'(npt_reg);
        limit_c = (mit_reg == '0) ? ITER_W'(1) : mit_reg;
        kd_c  = CB_W'(32'(k_c) * 32'(dim_c));
        npd_c = PB_W'(32'(np_c) * 32'(dim_c));
    end

    // Control and datapath registers.
    logic [3:0]            state_reg, state_next;
    logic [KC_W-1:0]       c_reg;
    logic [DC_W-1:0]       d_reg;
    logic [NP_W-1:0]       p_reg;
    logic [PB_W-1:0]       pbase_reg;
    logic [CB_W-1:0]       cbase_reg;
    logic [CB_W-1:0]       bbase_reg;
    logic [CB_W-1:0]       clr_reg;
    logic [KI_W-1:0]       best_reg;
    logic [DIST_W-1:0]     acc_reg;
    logic [DIST_W-1:0]     bestd_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic signed [DATA_W-1:0] old_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic                  moved_reg;
    logic                  bank_reg;
    logic [ITER_W-1:0]     round_reg;
    logic [PB_W-1:0]       pptr_reg;
    logic [CB_W-1:0]       cptr_reg;
    logic [CNT_W-1:0]      counts_reg [MAX_CLUSTERS];
    logic                  m_valid_reg;

    // Memories: points, two centroid banks, and the per-round sums.
    logic [DATA_W-1:0] pmem [PM_DEPTH];
    logic [DATA_W-1:0] cmem [2 * CB];
    logic [SUM_W-1:0]  smem [CB];

    logic              pm_we;
    logic [PA_W-1:0]   pm_waddr, pm_raddr;
    logic [DATA_W-1:0] pm_rd;
    logic [DATA_W-1:0] pm_wdata_w;
    logic              cm_we;
    logic [CM_AW-1:0]  cm_waddr, cm_raddr;
    logic [DATA_W-1:0] cm_wdata, cm_rd;
    logic              sm_we;
    logic [CA_W-1:0]   sm_waddr, sm_raddr;
    logic [SUM_W-1:0]  sm_wdata, sm_rd;

    assign pm_wdata_w = s_coord_value;

    always_ff @(posedge aclk) begin
        if (pm_we) pmem[pm_waddr] <= pm_wdata_w;
        pm_rd <= pmem[pm_raddr];
    end
    always_ff @(posedge aclk) begin
        if (cm_we) cmem[cm_waddr] <= cm_wdata;
        cm_rd <= cmem[cm_raddr];
    end
    always_ff @(posedge aclk) begin
        if (sm_we) smem[sm_waddr] <= sm_wdata;
        sm_rd <= smem[sm_raddr];
    end

    // Offsets of the current and the other centroid bank.
    logic [CM_AW-1:0] cur_off, oth_off;
    assign cur_off = bank_reg ? CM_AW'(CB) : '0;
    assign oth_off = bank_reg ? '0 : CM_AW'(CB);

    logic            in_acc;
    logic            d_last, c_last, p_last, o_last;
    logic [PB_W-1:0] pptr_cur, pptr_inc;
    logic [CB_W-1:0] cptr_cur, cptr_inc;
    logic signed [DATA_W:0]      diff;
    logic signed [2*DATA_W+1:0]  prod;
    logic [DIST_W-1:0]           acc_sum;
    logic [SUM_W-1:0]            pt_ext;
    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic signed [SUM_W-1:0]     div_q;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign d_last  = (DC_W'(d_reg + 1'b1) == dim_c);
    assign c_last  = (KC_W'(c_reg + 1'b1) == k_c);
    assign p_last  = (NP_W'(p_reg + 1'b1) == np_c);
    assign o_last  = c_last && d_last;
    assign acc_sum = acc_reg + DIST_W'(sq_reg);
    assign pt_ext  = {{(SUM_W-DATA_W){pm_rd[DATA_W-1]}}, pm_rd};

    // Load pointers wrap once they reach the configured extent.
    always_comb begin
        pptr_cur = (pptr_reg >= npd_c) ? '0 : pptr_reg;
        pptr_inc = PB_W'(pptr_cur + 1'b1);
        if (pptr_inc >= npd_c) pptr_inc = '0;
        cptr_cur = (cptr_reg >= kd_c) ? '0 : cptr_reg;
        cptr_inc = CB_W'(cptr_cur + 1'b1);
        if (cptr_inc >= kd_c) cptr_inc = '0;
    end

    // The squared difference: point against centroid while assigning,
    // old centroid against new one while updating.
    always_comb begin
        if (state_reg == ST_UMUL) begin
            diff = $signed({old_reg[DATA_W-1], old_reg}) - $signed({q_reg[DATA_W-1], q_reg});
        end else begin
            diff = $signed({pm_rd[DATA_W-1], pm_rd}) - $signed({cm_rd[DATA_W-1], cm_rd});
        end
        prod = diff * diff;
    end

    // Memory port steering.
    always_comb begin
        pm_we    = in_acc && (s_command == CMD_LOAD_POINT);
        pm_waddr = pptr_cur[PA_W-1:0];
        pm_raddr = PA_W'(pbase_reg + PB_W'(d_reg));

        cm_we    = 1'b0;
        cm_waddr = CM_AW'(cur_off + CM_AW'(cptr_cur));
        cm_wdata = s_coord_value;
        if (in_acc && (s_command == CMD_LOAD_CENTROID)) begin
            cm_we = 1'b1;
        end else if (state_reg == ST_UMUL) begin
            cm_we    = 1'b1;
            cm_waddr = CM_AW'(oth_off + CM_AW'(cbase_reg + CB_W'(d_reg)));
            cm_wdata = q_reg;
        end
        cm_raddr = CM_AW'(cur_off + CM_AW'(cbase_reg + CB_W'(d_reg)));

        sm_we    = 1'b0;
        sm_waddr = clr_reg[CA_W-1:0];
        sm_wdata = '0;
        if (state_reg == ST_CLR) begin
            sm_we = 1'b1;
        end else if (state_reg == ST_AWR) begin
            sm_we    = 1'b1;
            sm_waddr = CA_W'(bbase_reg + CB_W'(d_reg));
            sm_wdata = sm_rd + pt_ext;
        end
        if ((state_reg == ST_ARD) || (state_reg == ST_AWR)) begin
            sm_raddr = CA_W'(bbase_reg + CB_W'(d_reg));
        end else begin
            sm_raddr = CA_W'(cbase_reg + CB_W'(d_reg));
        end
    end

    assign div_start = (state_reg == ST_UDIV);

    kmc_divider #(
        .N (SUM_W),
        .D (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sm_rd),
        .divisor  (counts_reg[c_reg[KI_W-1:0]]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc && (s_command == CMD_RUN)) state_next = ST_CLR;
            ST_CLR:   if (CB_W'(clr_reg + 1'b1) == kd_c) state_next = ST_DRD;
            ST_DRD:   state_next = ST_DMUL;
            ST_DMUL:  state_next = ST_DADD;
            ST_DADD:  state_next = (d_last && c_last) ? ST_ARD : ST_DRD;
            ST_ARD:   state_next = ST_AWR;
            ST_AWR: begin
                if (!d_last) state_next = ST_ARD;
                else if (p_last) state_next = ST_URD;
                else state_next = ST_DRD;
            end
            ST_URD:   state_next = ST_UDIV;
            ST_UDIV:  state_next = ST_UWAIT;
            ST_UWAIT: if (div_done) state_next = ST_UMUL;
            ST_UMUL:  state_next = ST_UADD;
            ST_UADD:  state_next = (d_last && c_last) ? ST_REND : ST_URD;
            ST_REND: begin
                if (moved_reg && (ITER_W'(round_reg + 1'b1) < limit_c)) state_next = ST_CLR;
                else state_next = ST_ORD;
            end
            ST_ORD:   if (!m_valid_reg || m_ready) state_next = ST_OLD;
            ST_OLD:   state_next = o_last ? ST_IDLE : ST_ORD;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bank_reg    <= 1'b0;
            round_reg   <= '0;
            pptr_reg    <= '0;
            cptr_reg    <= '0;
            m_valid_reg <= 1'b0;
            moved_reg   <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++) counts_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (s_command)
                            CMD_LOAD_POINT:    pptr_reg <= pptr_inc;
                            CMD_LOAD_CENTROID: cptr_reg <= cptr_inc;
                            CMD_RUN: begin
                                pptr_reg  <= '0;
                                cptr_reg  <= '0;
                                round_reg <= '0;
                                clr_reg   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLR: begin
                    // Sums are swept to zero; the counts clear at once.
                    clr_reg <= CB_W'(clr_reg + 1'b1);
                    for (int i = 0; i < MAX_CLUSTERS; i++) counts_reg[i] <= '0;
                    p_reg     <= '0;
                    pbase_reg <= '0;
                    c_reg     <= '0;
                    cbase_reg <= '0;
                    d_reg     <= '0;
                    acc_reg   <= '0;
                end
                ST_DMUL: sq_reg <= prod[SQ_W-1:0];
                ST_DADD: begin
                    if (d_last) begin
                        // Strictly smaller wins, so a tie keeps the lower index.
                        if ((c_reg == '0) || (acc_sum < bestd_reg)) begin
                            bestd_reg <= acc_sum;
                            best_reg  <= c_reg[KI_W-1:0];
                            bbase_reg <= cbase_reg;
                        end
                        acc_reg <= '0;
                        d_reg   <= '0;
                        if (!c_last) begin
                            c_reg     <= KC_W'(c_reg + 1'b1);
                            cbase_reg <= CB_W'(cbase_reg + CB_W'(dim_c));
                        end
                    end else begin
                        acc_reg <= acc_sum;
                        d_reg   <= DC_W'(d_reg + 1'b1);
                    end
                end
                ST_AWR: begin
                    if (d_last) begin
                        counts_reg[best_reg] <= CNT_W'(counts_reg[best_reg] + 1'b1);
                        d_reg     <= '0;
                        c_reg     <= '0;
                        cbase_reg <= '0;
                        if (p_last) begin
                            acc_reg   <= '0;
                            moved_reg <= 1'b0;
                        end else begin
                            p_reg     <= NP_W'(p_reg + 1'b1);
                            pbase_reg <= PB_W'(pbase_reg + PB_W'(dim_c));
                        end
                    end else begin
                        d_reg <= DC_W'(d_reg + 1'b1);
                    end
                end
                ST_UDIV:  old_reg <= cm_rd;
                ST_UWAIT: if (div_done) q_reg <= div_q[DATA_W-1:0];
                ST_UMUL:  sq_reg <= prod[SQ_W-1:0];
                ST_UADD: begin
                    if (d_last) begin
                        if (acc_sum > DIST_W'(eps_reg)) moved_reg <= 1'b1;
                        acc_reg <= '0;
                        d_reg   <= '0;
                        if (!c_last) begin
                            c_reg     <= KC_W'(c_reg + 1'b1);
                            cbase_reg <= CB_W'(cbase_reg + CB_W'(dim_c));
                        end
                    end else begin
                        acc_reg <= acc_sum;
                        d_reg   <= DC_W'(d_reg + 1'b1);
                    end
                end
                ST_REND: begin
                    // The new centroids become current; a later run goes on from them.
                    bank_reg  <= ~bank_reg;
                    round_reg <= ITER_W'(round_reg + 1'b1);
                    clr_reg   <= '0;
                    c_reg     <= '0;
                    cbase_reg <= '0;
                    d_reg     <= '0;
                end
                ST_OLD: begin
                    m_valid_reg       <= 1'b1;
                    m_cluster_index   <= IDX_OUT_W'(c_reg);
                    m_coord_index     <= IDX_OUT_W'(d_reg);
                    m_centroid_value  <= cm_rd;
                    m_iterations_used <= round_reg;
                    m_last            <= o_last;
                    if (d_last) begin
                        d_reg     <= '0;
                        c_reg     <= KC_W'(c_reg + 1'b1);
                        cbase_reg <= CB_W'(cbase_reg + CB_W'(dim_c));
                    end else begin
                        d_reg <= DC_W'(d_reg + 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    // A result item only appears from the output load step.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OLD))
        else $error("result item raised outside the output load step");
    // The divider runs only while the sequencer waits for it.
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_UWAIT))
        else $error("divider busy outside the wait step");
    // An output load never overwrites an item not yet taken.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OLD) |-> !m_valid_reg)
        else $error("output register overwritten");
    // The round count never passes the round limit.
    a_round_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OLD) |-> (round_reg <= limit_c && round_reg != '0))
        else $error("round count out of range");
`endif

endmodule
`default_nettype wire
